FILE: sv/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and helpers of the word set membership matcher
// Holds the sequencer states, the cell write controls and the separator test.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ORD_W  = 7;
  localparam int unsigned OLEN_W = 5;
  localparam logic [ORD_W-1:0]  ORD_MAX  = 7'd127;
  localparam logic [OLEN_W-1:0] OLEN_MAX = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACT,
    ST_SCAN
  } state_t;

  // Write strobes broadcast to the cell row.
  typedef struct packed {
    logic ref_we;
    logic seen_we;
  } wr_ctl_t;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    logic r;
    r = 1'b0;
    case (c)
      8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2D, 8'h2E, 8'h21, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/wsm_if.sv
// ----------------------------------------------------------------------------
// wsm_in_if / wsm_out_if: request channels of the word set membership matcher
// Valid/ready channels carrying character requests and word results.
// ----------------------------------------------------------------------------
interface wsm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;
  logic       end_of_string;
  modport source (output valid, mode, char_code, end_of_string, input ready);
  modport sink   (input valid, mode, char_code, end_of_string, output ready);
endinterface

interface wsm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] word_ordinal;
  logic [4:0] word_length;
  logic       found_in_reference;
  modport source (output valid, word_ordinal, word_length, found_in_reference, input ready);
  modport sink   (input valid, word_ordinal, word_length, found_in_reference, output ready);
endinterface

FILE: sv/wsm_cell.sv
// ----------------------------------------------------------------------------
// wsm_cell: one word slot of the reference table and of the seen table
// Compares its stored words with the pending word and passes the hit on.
// ----------------------------------------------------------------------------
module wsm_cell #(
  parameter int unsigned WORD_CHARS = 16,
  parameter int unsigned LEN_W      = 5,
  parameter int unsigned CNT_W      = 8,
  parameter int unsigned IDX        = 0
) (
  input  logic                      clk,
  input  logic [wsm_pkg::CHAR_W-1:0] word [WORD_CHARS],
  input  logic [LEN_W-1:0]          len,
  input  wsm_pkg::wr_ctl_t          wr,
  input  logic [CNT_W-1:0]          ref_cnt,
  input  logic [CNT_W-1:0]          seen_cnt,
  input  logic                      ref_hit_in,
  input  logic                      seen_hit_in,
  output logic                      ref_hit_r,
  output logic                      seen_hit_r
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [wsm_pkg::CHAR_W-1:0] ref_chars_r  [WORD_CHARS];
  logic [wsm_pkg::CHAR_W-1:0] seen_chars_r [WORD_CHARS];
  logic [LEN_W-1:0]           ref_len_r;
  logic [LEN_W-1:0]           seen_len_r;
  logic                       ref_eq;
  logic                       seen_eq;
  logic                       ref_hit_nxt;
  logic                       seen_hit_nxt;

  always_comb begin
    ref_eq  = (ref_len_r == len);
    seen_eq = (seen_len_r == len);
    for (int j = 0; j < WORD_CHARS; j++) begin
      if (LEN_W'(j) < len) begin
        if (ref_chars_r[j] != word[j]) ref_eq = 1'b0;
        if (seen_chars_r[j] != word[j]) seen_eq = 1'b0;
      end
    end
    ref_hit_nxt  = ref_hit_in | (ref_eq & (MY_IDX < ref_cnt));
    seen_hit_nxt = seen_hit_in | (seen_eq & (MY_IDX < seen_cnt));
  end

  always_ff @(posedge clk) begin
    ref_hit_r  <= ref_hit_nxt;
    seen_hit_r <= seen_hit_nxt;
    if (wr.ref_we && ref_cnt == MY_IDX) begin
      ref_chars_r <= word;
      ref_len_r   <= len;
    end
    if (wr.seen_we && seen_cnt == MY_IDX) begin
      seen_chars_r <= word;
      seen_len_r   <= len;
    end
  end

endmodule

FILE: sv/word_set_membership_matcher_unit.sv
// ----------------------------------------------------------------------------
// word_set_membership_matcher_unit: word set membership matcher
// Splits reference and query text into words and reports unseen query words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character request: mode (0 reference, 1 query),
//   char_code and end_of_string. out_ch carries one result per new query
//   word: its ordinal, its saturated length and whether a reference word
//   matches it. Both channels move a request when valid and ready are high.
//   Each character passes through ACT, and the block takes the next one only
//   once back in IDLE. One that closes a non-empty query word also passes SCAN:
//   the hit flags ripple down the row of WORD_SLOTS cells one cell per cycle,
//   and the result is registered at the end of that sweep.
//   Reset (rst_n low, synchronous) empties both tables, the pending word and
//   the ordinal; the tables are tracked by fill counts, so no clearing pass
//   is needed. The end of a query string empties them the same way.
//   While a result waits on a stalled receiver, the block keeps taking
//   characters; the next result, and intake with it, waits until output frees.
// ----------------------------------------------------------------------------
module word_set_membership_matcher_unit #(
  parameter int unsigned WORD_CHARS = 16,
  parameter int unsigned WORD_SLOTS = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  wsm_in_if.sink    in_ch,
  wsm_out_if.source out_ch
);

  localparam int unsigned LEN_W = $clog2(WORD_CHARS + 1);
  localparam int unsigned CI_W  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int unsigned CNT_W = $clog2(WORD_SLOTS + 1);
  localparam int unsigned SC_W  = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WORD_CHARS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WORD_SLOTS);
  localparam logic [SC_W-1:0]  SC_LAST  = SC_W'(WORD_SLOTS - 1);

  wsm_pkg::state_t  state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic             eos_r, eos_nxt;
  logic             close_r, close_nxt;
  logic [7:0]       cur_chars_r [WORD_CHARS];
  logic [7:0]       cur_chars_nxt [WORD_CHARS];
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [CNT_W-1:0] ref_cnt_r, ref_cnt_nxt;
  logic [CNT_W-1:0] seen_cnt_r, seen_cnt_nxt;
  logic [6:0]       ord_r, ord_nxt;
  logic [SC_W-1:0]  scan_r, scan_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_ord_r, out_ord_nxt;
  logic [4:0]       out_len_r, out_len_nxt;
  logic             out_found_r, out_found_nxt;
  logic             finish;
  logic [31:0]      len32;
  wsm_pkg::wr_ctl_t wr;

  logic ref_hit  [WORD_SLOTS+1];
  logic seen_hit [WORD_SLOTS+1];

  assign ref_hit[0]  = 1'b0;
  assign seen_hit[0] = 1'b0;

  for (genvar i = 0; i < WORD_SLOTS; i++) begin : g_cell
    wsm_cell #(
      .WORD_CHARS(WORD_CHARS),
      .LEN_W     (LEN_W),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .word       (cur_chars_r),
      .len        (cur_len_r),
      .wr         (wr),
      .ref_cnt    (ref_cnt_r),
      .seen_cnt   (seen_cnt_r),
      .ref_hit_in (ref_hit[i]),
      .seen_hit_in(seen_hit[i]),
      .ref_hit_r  (ref_hit[i+1]),
      .seen_hit_r (seen_hit[i+1])
    );
  end

  assign in_ch.ready               = (state_r == wsm_pkg::ST_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.word_ordinal       = out_ord_r;
  assign out_ch.word_length        = out_len_r;
  assign out_ch.found_in_reference = out_found_r;
  assign len32                     = 32'(cur_len_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    eos_nxt       = eos_r;
    close_nxt     = close_r;
    cur_chars_nxt = cur_chars_r;
    cur_len_nxt   = cur_len_r;
    ref_cnt_nxt   = ref_cnt_r;
    seen_cnt_nxt  = seen_cnt_r;
    ord_nxt       = ord_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_ord_nxt   = out_ord_r;
    out_len_nxt   = out_len_r;
    out_found_nxt = out_found_r;
    wr            = '0;
    finish        = 1'b0;

    case (state_r)
      wsm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          eos_nxt   = in_ch.end_of_string;
          close_nxt = wsm_pkg::is_sep(in_ch.char_code) | in_ch.end_of_string;
          if (!wsm_pkg::is_sep(in_ch.char_code) && cur_len_r < LEN_FULL) begin
            cur_chars_nxt[cur_len_r[CI_W-1:0]] = in_ch.char_code;
            cur_len_nxt = cur_len_r + LEN_W'(1);
          end
          state_nxt = wsm_pkg::ST_ACT;
        end
      end
      wsm_pkg::ST_ACT: begin
        if (close_r && cur_len_r != '0) begin
          if (!mode_r) begin
            if (ref_cnt_r < CNT_FULL) begin
              wr.ref_we   = 1'b1;
              ref_cnt_nxt = ref_cnt_r + CNT_W'(1);
            end
            finish = 1'b1;
          end else begin
            scan_nxt  = '0;
            state_nxt = wsm_pkg::ST_SCAN;
          end
        end else begin
          finish = 1'b1;
        end
      end
      wsm_pkg::ST_SCAN: begin
        if (scan_r != SC_LAST) begin
          scan_nxt = scan_r + SC_W'(1);
        end else if (seen_hit[WORD_SLOTS]) begin
          if (ord_r != wsm_pkg::ORD_MAX) ord_nxt = ord_r + 7'd1;
          finish = 1'b1;
        end else if (!out_valid_nxt) begin
          // The output register is free this cycle, so the result goes out.
          out_valid_nxt = 1'b1;
          out_ord_nxt   = ord_r;
          out_len_nxt   = (len32 > 32'd31) ? wsm_pkg::OLEN_MAX : len32[4:0];
          out_found_nxt = ref_hit[WORD_SLOTS];
          if (seen_cnt_r < CNT_FULL) begin
            wr.seen_we   = 1'b1;
            seen_cnt_nxt = seen_cnt_r + CNT_W'(1);
          end
          if (ord_r != wsm_pkg::ORD_MAX) ord_nxt = ord_r + 7'd1;
          finish = 1'b1;
        end
      end
      default: state_nxt = wsm_pkg::ST_IDLE;
    endcase

    if (finish) begin
      state_nxt = wsm_pkg::ST_IDLE;
      if (close_r) cur_len_nxt = '0;
      if (mode_r && eos_r) begin
        ref_cnt_nxt  = '0;
        seen_cnt_nxt = '0;
        ord_nxt      = '0;
        cur_len_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsm_pkg::ST_IDLE;
      cur_len_r   <= '0;
      ref_cnt_r   <= '0;
      seen_cnt_r  <= '0;
      ord_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_len_r   <= cur_len_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
      seen_cnt_r  <= seen_cnt_nxt;
      ord_r       <= ord_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    eos_r       <= eos_nxt;
    close_r     <= close_nxt;
    cur_chars_r <= cur_chars_nxt;
    scan_r      <= scan_nxt;
    out_ord_r   <= out_ord_nxt;
    out_len_r   <= out_len_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule

FILE: test/tb_word_set_membership_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_set_membership_matcher_unit: self-checking bench of the matcher
// Streams reference and query text through the request channel, predicts
// every word result in the bench and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_word_set_membership_matcher_unit;

  localparam int unsigned NCH   = 16;
  localparam int unsigned NSLOT = 128;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       eos;
  } char_req_t;

  typedef struct packed {
    logic [6:0] ordinal;
    logic [4:0] len;
    logic       found;
  } word_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsm_in_if  in_ch ();
  wsm_out_if out_ch ();

  word_set_membership_matcher_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  char_req_t pending_chars[$];
  word_res_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int got = 0;
  int hits = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Bench copy of the matcher state.
  logic [7:0] ref_tab [NSLOT][NCH];
  logic [4:0] ref_len [NSLOT];
  int         ref_cnt;
  logic [7:0] seen_tab [NSLOT][NCH];
  logic [4:0] seen_len [NSLOT];
  int         seen_cnt;
  logic [7:0] cur_word [NCH];
  int         cur_len;
  int         ordinal;

  function automatic bit sep_char(logic [7:0] c);
    return c inside {8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2D, 8'h2E, 8'h21, 8'h3F};
  endfunction

  function automatic bit word_in_ref();
    bit m;
    for (int i = 0; i < ref_cnt; i++) begin
      m = (ref_len[i] == cur_len);
      for (int k = 0; k < cur_len; k++) if (ref_tab[i][k] != cur_word[k]) m = 0;
      if (m) return 1;
    end
    return 0;
  endfunction

  function automatic bit word_seen();
    bit m;
    for (int i = 0; i < seen_cnt; i++) begin
      m = (seen_len[i] == cur_len);
      for (int k = 0; k < cur_len; k++) if (seen_tab[i][k] != cur_word[k]) m = 0;
      if (m) return 1;
    end
    return 0;
  endfunction

  task automatic predict_word(input char_req_t r);
    bit sep;
    word_res_t w;
    sep = sep_char(r.ch);
    if (!sep && cur_len < NCH) begin
      cur_word[cur_len] = r.ch;
      cur_len++;
    end
    if ((sep || r.eos) && cur_len > 0) begin
      if (!r.mode) begin
        if (ref_cnt < NSLOT) begin
          for (int k = 0; k < NCH; k++) ref_tab[ref_cnt][k] = (k < cur_len) ? cur_word[k] : 8'h0;
          ref_len[ref_cnt] = 5'(cur_len);
          ref_cnt++;
        end
      end else begin
        if (!word_seen()) begin
          w.ordinal = 7'(ordinal);
          w.len = 5'(cur_len);
          w.found = word_in_ref();
          if (seen_cnt < NSLOT) begin
            for (int k = 0; k < NCH; k++)
              seen_tab[seen_cnt][k] = (k < cur_len) ? cur_word[k] : 8'h0;
            seen_len[seen_cnt] = 5'(cur_len);
            seen_cnt++;
          end
          expected_words.push_back(w);
        end
        if (ordinal < 127) ordinal++;
      end
    end
    if (sep || r.eos) cur_len = 0;
    if (r.mode && r.eos) begin
      ref_cnt = 0;
      seen_cnt = 0;
      cur_len = 0;
      ordinal = 0;
    end
  endtask

  // Driver: a request stays on the channel until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word('{in_ch.mode, in_ch.char_code, in_ch.end_of_string});
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          {in_ch.mode, in_ch.char_code, in_ch.end_of_string} <= pending_chars.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    word_res_t e;
    cycles++;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ord=%0d len=%0d found=%0d", $time,
                   out_ch.word_ordinal, out_ch.word_length, out_ch.found_in_reference);
        end else begin
          e = expected_words.pop_front();
          if (e.found) hits++;
          if (out_ch.word_ordinal != e.ordinal) begin
            errors++;
            $display("%0t: word_ordinal expected %0d actual %0d", $time, e.ordinal,
                     out_ch.word_ordinal);
          end
          if (out_ch.word_length != e.len) begin
            errors++;
            $display("%0t: word_length expected %0d actual %0d", $time, e.len,
                     out_ch.word_length);
          end
          if (out_ch.found_in_reference != e.found) begin
            errors++;
            $display("%0t: found_in_reference expected %0d actual %0d", $time, e.found,
                     out_ch.found_in_reference);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_char(input bit m, input logic [7:0] c, input bit eos);
    pending_chars.push_back('{m, c, eos});
  endtask

  task automatic push_text(input bit m, input string s, input bit close);
    for (int i = 0; i < s.len(); i++) push_char(m, s[i], close && (i == s.len() - 1));
  endtask

  // A random word taken from a small vocabulary so that repeats and hits occur.
  function automatic string rand_word();
    string s;
    int n;
    logic [7:0] b;
    s = "";
    n = ($urandom_range(19) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      b = 8'(8'h61 + $urandom_range(2));
      s = {s, string'(b)};
    end
    return s;
  endfunction

  function automatic logic [7:0] rand_sep();
    logic [7:0] t [8] = '{8'h20, 8'h2C, 8'h3B, 8'h3A, 8'h2D, 8'h2E, 8'h21, 8'h3F};
    return t[$urandom_range(7)];
  endfunction

  task automatic push_sentence(input bit m, input int words, input bit close);
    for (int i = 0; i < words; i++) begin
      push_text(m, rand_word(), 0);
      if (i < words - 1 || $urandom_range(1)) push_char(m, rand_sep(), 0);
      if ($urandom_range(5) == 0) push_char(m, rand_sep(), 0);
    end
    push_char(m, close ? rand_sep() : 8'h61, close);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (2 * NSLOT + 10) @(posedge clk);
  endtask

  initial begin
    int phase_items;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.char_code = 8'h0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready = 1'b1;
    ref_cnt = 0; seen_cnt = 0; cur_len = 0; ordinal = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: separators, empty words, long words, byte 0 and 255, repeats,
    // mode change inside a word and a reference word arriving mid-query.
    // Byte 0 is pushed on its own since a string drops null characters.
    push_text(0, "ab,,x", 0);
    push_char(0, 8'h00, 0);
    push_text(0, "\377 abcdefghijklmnopqrst-", 1);
    push_text(1, "ab", 0);
    push_text(0, "c;", 0);
    push_text(1, "ab abcdefghijklmnopqXYZ.ab!x", 0);
    push_char(1, 8'h00, 0);
    push_text(1, "\377?q", 0);
    push_text(0, "q ", 0);
    push_text(1, "q:", 1);
    wait_drained();

    // Saturation: more than WORD_SLOTS distinct words and ordinals past 127.
    for (int i = 0; i < 140; i++) begin
      push_char(0, 8'(8'h41 + i % 26), 0);
      push_char(0, 8'(8'h41 + i / 26), 0);
      push_char(0, 8'h20, 0);
    end
    for (int i = 0; i < 135; i++) begin
      push_char(1, 8'(8'h41 + i % 26), 0);
      push_char(1, 8'(8'h41 + i / 26), 0);
      push_char(1, 8'h2C, 0);
    end
    push_text(1, "AA FF", 1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 13 : 47) : 0;
      recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 13 : 47) : 0;
      phase_items = sent + pending_chars.size();
      while (sent + pending_chars.size() < phase_items + 240) begin
        case ($urandom_range(9))
          0: push_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
          1, 2, 3: push_sentence(0, $urandom_range(1, 5), 1'($urandom_range(1)));
          default: push_sentence(1, $urandom_range(1, 6), $urandom_range(3) == 0);
        endcase
        if (pending_chars.size() > 200) @(posedge clk);
      end
      wait_drained();
    end

    $display("Streamed %0d characters, checked %0d word results (%0d found).",
             sent, got, hits);
    $display("Covered separators, long and empty words, table and ordinal saturation.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

FILE: filelist.f
sv/wsm_pkg.sv
sv/wsm_if.sv
sv/wsm_cell.sv
sv/word_set_membership_matcher_unit.sv
test/tb_word_set_membership_matcher_unit.sv
